### design/assert_macros.svh
// Assertion macros used by the port checker of the calendar block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCD_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("calendar port check failed");

// Next-cycle implication, disabled during reset.
`define BCD_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("calendar port check failed");

`endif

### design/bcdcal_pkg.sv
// Types, constants and month table of the BCD calendar block.
`timescale 1ns / 1ps

package bcdcal_pkg;

  // Word kinds
  localparam logic KIND_ADVANCE = 1'b0;
  localparam logic KIND_LOAD    = 1'b1;

  localparam logic [13:0] YEAR_MOD  = 14'd10000;
  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // Packed BCD date, thousands digit of the year on top
  typedef struct packed {
    logic [3:0] y3;
    logic [3:0] y2;
    logic [3:0] y1;
    logic [3:0] y0;
    logic [3:0] m1;
    logic [3:0] m0;
    logic [3:0] d1;
    logic [3:0] d0;
  } bcd_t;

  // Date held both in binary and in BCD
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    bcd_t        bcd;
  } date_t;

  // Word leaving the load pipeline
  typedef struct packed {
    logic  kind;
    date_t date;
  } ld_word_t;

  localparam date_t RESET_DATE = '{
    year:  14'd2013,
    month: 4'd6,
    day:   5'd14,
    bcd:   '{y3: 4'd2, y2: 4'd0, y1: 4'd1, y0: 4'd3,
             m1: 4'd0, m0: 4'd6, d1: 4'd1, d0: 4'd4}
  };

  // Days in a month; months outside 1..12 count as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### design/bcdcal_load_conv.sv
// Four-stage pipeline that turns a load word's binary fields into BCD digits.
`timescale 1ns / 1ps

module bcdcal_load_conv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [13:0]          set_year,
  input  logic [3:0]           set_month,
  input  logic [4:0]           set_day,
  output logic                 word_valid,
  input  logic                 word_ready,
  output bcdcal_pkg::ld_word_t word
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  bcdcal_pkg::ld_word_t s1_w, s2_w, s3_w, s4_w;
  bcdcal_pkg::ld_word_t s1_w_next, s2_w_next, s3_w_next, s4_w_next;
  logic [9:0] s2_rem, s2_rem_next;
  logic [6:0] s3_rem, s3_rem_next;

  // Stage enables: a stage loads when empty or when its word moves on
  assign en4      = !v4 || word_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: year modulo 10000, month and day digits
  always_comb begin
    s1_w_next            = '0;
    s1_w_next.kind       = kind;
    s1_w_next.date.year  = (set_year >= bcdcal_pkg::YEAR_MOD) ?
                           14'(set_year - bcdcal_pkg::YEAR_MOD) : set_year;
    s1_w_next.date.month = set_month;
    s1_w_next.date.day   = set_day;
    s1_w_next.date.bcd.m1 = (set_month >= 4'd10) ? 4'd1 : 4'd0;
    s1_w_next.date.bcd.m0 = (set_month >= 4'd10) ? 4'(set_month - 4'd10) : set_month;
    priority if (set_day >= 5'd30) s1_w_next.date.bcd.d1 = 4'd3;
    else if (set_day >= 5'd20)     s1_w_next.date.bcd.d1 = 4'd2;
    else if (set_day >= 5'd10)     s1_w_next.date.bcd.d1 = 4'd1;
    else                           s1_w_next.date.bcd.d1 = 4'd0;
    s1_w_next.date.bcd.d0 = 4'(set_day - 5'(s1_w_next.date.bcd.d1) * 5'd10);
  end

  // Stage 2: thousands digit
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (s1_w.date.year >= 14'(k * 1000)) dig = 4'(k);
    end
    s2_w_next             = s1_w;
    s2_w_next.date.bcd.y3 = dig;
    s2_rem_next           = 10'(s1_w.date.year - 14'(dig) * 14'd1000);
  end

  // Stage 3: hundreds digit
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (s2_rem >= 10'(k * 100)) dig = 4'(k);
    end
    s3_w_next             = s2_w;
    s3_w_next.date.bcd.y2 = dig;
    s3_rem_next           = 7'(s2_rem - 10'(dig) * 10'd100);
  end

  // Stage 4: tens and units digits
  always_comb begin
    logic [3:0] dig;
    dig = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (s3_rem >= 7'(k * 10)) dig = 4'(k);
    end
    s4_w_next             = s3_w;
    s4_w_next.date.bcd.y1 = dig;
    s4_w_next.date.bcd.y0 = 4'(s3_rem - 7'(dig) * 7'd10);
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_w <= s1_w_next;
    if (en2 && v1) begin
      s2_w   <= s2_w_next;
      s2_rem <= s2_rem_next;
    end
    if (en3 && v2) begin
      s3_w   <= s3_w_next;
      s3_rem <= s3_rem_next;
    end
    if (en4 && v3) s4_w <= s4_w_next;
  end

  assign word_valid = v4;
  assign word       = s4_w;

endmodule

### design/bcdcal_date_next.sv
// Next-date logic: load the given date or move the current date on by one day.
`timescale 1ns / 1ps

module bcdcal_date_next (
  input  bcdcal_pkg::date_t    cur,
  input  bcdcal_pkg::ld_word_t word,
  output bcdcal_pkg::date_t    nxt
);

  logic       leap;
  logic [4:0] cent_sum;
  logic [4:0] len;

  // Leap year: multiple of 4, and for a century year its top two digits a multiple of 4
  assign cent_sum = {cur.bcd.y3, 1'b0} + 5'(cur.bcd.y2);
  assign leap = (cur.year[1:0] == 2'd0) &&
                (!(cur.bcd.y1 == 4'd0 && cur.bcd.y0 == 4'd0) || (cent_sum[1:0] == 2'd0));
  assign len  = bcdcal_pkg::month_len(cur.month, leap);

  always_comb begin
    nxt = cur;
    if (word.kind == bcdcal_pkg::KIND_LOAD) begin
      nxt = word.date;
    end else if (cur.day < len) begin
      // Day step inside the month
      nxt.day = 5'(cur.day + 5'd1);
      if (cur.bcd.d0 == 4'd9) begin
        nxt.bcd.d0 = 4'd0;
        nxt.bcd.d1 = 4'(cur.bcd.d1 + 4'd1);
      end else begin
        nxt.bcd.d0 = 4'(cur.bcd.d0 + 4'd1);
      end
    end else begin
      nxt.day    = 5'd1;
      nxt.bcd.d1 = 4'd0;
      nxt.bcd.d0 = 4'd1;
      if (cur.month >= bcdcal_pkg::MONTH_DEC) begin
        // New year, BCD ripple carry wraps 9999 to 0000
        nxt.month  = 4'd1;
        nxt.bcd.m1 = 4'd0;
        nxt.bcd.m0 = 4'd1;
        nxt.year   = (cur.year == bcdcal_pkg::YEAR_MAX) ? 14'd0 : 14'(cur.year + 14'd1);
        nxt.bcd.y0 = (cur.bcd.y0 == 4'd9) ? 4'd0 : 4'(cur.bcd.y0 + 4'd1);
        if (cur.bcd.y0 == 4'd9) begin
          nxt.bcd.y1 = (cur.bcd.y1 == 4'd9) ? 4'd0 : 4'(cur.bcd.y1 + 4'd1);
          if (cur.bcd.y1 == 4'd9) begin
            nxt.bcd.y2 = (cur.bcd.y2 == 4'd9) ? 4'd0 : 4'(cur.bcd.y2 + 4'd1);
            if (cur.bcd.y2 == 4'd9) begin
              nxt.bcd.y3 = (cur.bcd.y3 == 4'd9) ? 4'd0 : 4'(cur.bcd.y3 + 4'd1);
            end
          end
        end
      end else begin
        // Next month, same year
        nxt.month = 4'(cur.month + 4'd1);
        if (cur.bcd.m0 == 4'd9) begin
          nxt.bcd.m0 = 4'd0;
          nxt.bcd.m1 = 4'(cur.bcd.m1 + 4'd1);
        end else begin
          nxt.bcd.m0 = 4'(cur.bcd.m0 + 4'd1);
        end
      end
    end
  end

endmodule

### design/bcd_calendar_day_advance_top.sv
// An accepted word is captured by the first load-digit stage at the accepting edge, passes
// three more stages, then the date register; sustained rate is one word per cycle while
// out_ready keeps the output from stalling.
// The date register is the only state carried between words; each stage holds one word.
// Reset (rst, synchronous) empties the pipeline and sets the date to 2013-06-14.
`timescale 1ns / 1ps

module bcd_calendar_day_advance_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [13:0] set_year,
  input  logic [3:0]  set_month,
  input  logic [4:0]  set_day,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [31:0] date_bcd
);

  logic                 conv_valid;
  logic                 en_out;
  bcdcal_pkg::ld_word_t conv_word;
  bcdcal_pkg::date_t    cur;
  bcdcal_pkg::date_t    cur_next;

  assign en_out = !out_valid || out_ready;

  // Load digit conversion
  bcdcal_load_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .set_year   (set_year),
    .set_month  (set_month),
    .set_day    (set_day),
    .word_valid (conv_valid),
    .word_ready (en_out),
    .word       (conv_word)
  );

  // Date update
  bcdcal_date_next u_next (
    .cur  (cur),
    .word (conv_word),
    .nxt  (cur_next)
  );

  // Date register doubles as the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= bcdcal_pkg::RESET_DATE;
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= conv_valid;
      if (conv_valid) cur <= cur_next;
    end
  end

  assign year     = cur.year;
  assign month    = cur.month;
  assign day      = cur.day;
  assign date_bcd = cur.bcd;

endmodule

### design/bcdcal_checker.sv
// Port checker for the calendar block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bcdcal_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic [13:0] set_year,
  input logic [3:0]  set_month,
  input logic [4:0]  set_day,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [31:0] date_bcd
);

  // Two BCD digits to binary
  function automatic logic [6:0] bcd2_val(input logic [7:0] b);
    return 7'({3'd0, b[7:4]} * 7'd10 + {3'd0, b[3:0]});
  endfunction

  // Four BCD digits to binary
  function automatic logic [13:0] bcd4_val(input logic [15:0] b);
    return 14'({10'd0, b[15:12]} * 14'd1000 + {10'd0, b[11:8]} * 14'd100
             + {10'd0, b[7:4]} * 14'd10 + {10'd0, b[3:0]});
  endfunction

  // A stalled output word holds
  `BCD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(date_bcd) && $stable(year))
  // Binary and BCD views of the date agree
  `BCD_ASSERT_IMPLY(a_day_match, clk, rst, out_valid, {2'd0, day} == bcd2_val(date_bcd[7:0]))
  `BCD_ASSERT_IMPLY(a_month_match, clk, rst, out_valid, {3'd0, month} == bcd2_val(date_bcd[15:8]))
  `BCD_ASSERT_IMPLY(a_year_match, clk, rst, out_valid, year == bcd4_val(date_bcd[31:16]))

endmodule

bind bcd_calendar_day_advance_top bcdcal_checker u_chk (.*);

### verif/tb_top.sv
// Self-checking testbench for the BCD calendar day-advance block.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WORD_COUNT  = 1250;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 10;

  // Tracks the stored date and keeps the dates the block still owes us
  class date_tracker;
    logic [3:0] digit[8];
    bcdcal_pkg::date_t due_dates[$];
    int unsigned checked;
    int unsigned errors;

    function new();
      digit   = '{4'd2, 4'd0, 4'd1, 4'd3, 4'd0, 4'd6, 4'd1, 4'd4};
      checked = 0;
      errors  = 0;
    endfunction

    function int unsigned year_num();
      return digit[0] * 1000 + digit[1] * 100 + digit[2] * 10 + digit[3];
    endfunction

    function int unsigned month_num();
      return digit[4] * 10 + digit[5];
    endfunction

    function int unsigned day_num();
      return digit[6] * 10 + digit[7];
    endfunction

    function bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Months outside 1..12 run 31 days
    function int unsigned month_days(int unsigned m, int unsigned y);
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    function void store(int unsigned y, int unsigned m, int unsigned d);
      y = y % 10000;
      digit[0] = 4'((y / 1000) % 10);
      digit[1] = 4'((y / 100) % 10);
      digit[2] = 4'((y / 10) % 10);
      digit[3] = 4'(y % 10);
      digit[4] = 4'((m / 10) % 10);
      digit[5] = 4'(m % 10);
      digit[6] = 4'((d / 10) % 10);
      digit[7] = 4'(d % 10);
    endfunction

    // Apply one accepted word and queue the date it must produce
    function void note_word(logic k, logic [13:0] sy, logic [3:0] sm, logic [4:0] sd);
      int unsigned y, m, d;
      bcdcal_pkg::date_t due;
      if (k == bcdcal_pkg::KIND_LOAD) begin
        store(32'(sy), 32'(sm), 32'(sd));
      end else begin
        y = year_num();
        m = month_num();
        d = day_num();
        if (d < month_days(m, y)) begin
          d++;
        end else begin
          d = 1;
          if (m >= 12) begin
            m = 1;
            y = (y + 1) % 10000;
          end else begin
            m++;
          end
        end
        store(y, m, d);
      end
      due.year  = 14'(year_num());
      due.month = 4'(month_num());
      due.day   = 5'(day_num());
      due.bcd   = {digit[0], digit[1], digit[2], digit[3],
                   digit[4], digit[5], digit[6], digit[7]};
      due_dates.push_back(due);
    endfunction

    function void check_result(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                               logic [31:0] bcd);
      bcdcal_pkg::date_t due;
      if (due_dates.size() == 0) begin
        $display("%0t: result %0d-%0d-%0d (%h) with nothing outstanding", $time, y, m, d, bcd);
        errors++;
        return;
      end
      due = due_dates.pop_front();
      checked++;
      if (y !== due.year) begin
        $display("%0t: year mismatch, expected %0d, actual %0d", $time, due.year, y);
        errors++;
      end
      if (m !== due.month) begin
        $display("%0t: month mismatch, expected %0d, actual %0d", $time, due.month, m);
        errors++;
      end
      if (d !== due.day) begin
        $display("%0t: day mismatch, expected %0d, actual %0d", $time, due.day, d);
        errors++;
      end
      if (bcd !== due.bcd) begin
        $display("%0t: date_bcd mismatch, expected %h, actual %h", $time, due.bcd, bcd);
        errors++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic        kind      = bcdcal_pkg::KIND_ADVANCE;
  logic [13:0] set_year  = '0;
  logic [3:0]  set_month = '0;
  logic [4:0]  set_day   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [31:0] date_bcd;

  date_tracker sb = new();
  int unsigned burst_left = 0;
  int unsigned n_loads    = 0;
  int unsigned n_advances = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_phase = 0;
  int unsigned stall_mode  = 0;

  // Output words seen at the falling edge, scored at the next rising edge
  logic        snap_fire = 1'b0;
  logic [13:0] snap_year;
  logic [3:0]  snap_month;
  logic [4:0]  snap_day;
  logic [31:0] snap_bcd;

  bcd_calendar_day_advance_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .set_year  (set_year),
    .set_month (set_month),
    .set_day   (set_day),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .year      (year),
    .month     (month),
    .day       (day),
    .date_bcd  (date_bcd)
  );

  always #10 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver backpressure: modes from always-ready to long stalls
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 120);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (stall_phase % 4 != 0);
      default: out_ready <= (stall_phase % 11 == 0);
    endcase
  end

  always @(negedge clk) begin
    snap_fire  = out_valid && out_ready && !rst;
    snap_year  = year;
    snap_month = month;
    snap_day   = day;
    snap_bcd   = date_bcd;
  end

  always @(posedge clk) begin
    if (snap_fire) begin
      sb.check_result(snap_year, snap_month, snap_day, snap_bcd);
    end
  end

  // Hand one word to the block, with bursts and random gaps in between
  task automatic put_word(logic k, logic [13:0] y, logic [3:0] m, logic [4:0] d);
    int unsigned gap;
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    kind      <= k;
    set_year  <= y;
    set_month <= m;
    set_day   <= d;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end
    sb.note_word(k, y, m, d);
    if (k == bcdcal_pkg::KIND_LOAD) n_loads++;
    else n_advances++;
  endtask

  task automatic advance_days(int unsigned steps);
    repeat (steps) begin
      put_word(bcdcal_pkg::KIND_ADVANCE, 14'($urandom_range(0, 16383)),
               4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
    end
  endtask

  task automatic load_and_advance(int unsigned y, int unsigned m, int unsigned d,
                                  int unsigned steps);
    put_word(bcdcal_pkg::KIND_LOAD, 14'(y), 4'(m), 5'(d));
    advance_days(steps);
  endtask

  // Hold off the sender until every outstanding date has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_dates.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned pick, y, m, d, len, steps;
    bit paused;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset date, leap rules, month ends, rollover, odd loads
    advance_days(1);
    load_and_advance(2000, 2, 28, 2);   // leap by 400
    load_and_advance(1900, 2, 28, 1);   // century, not leap
    load_and_advance(2024, 2, 29, 1);
    load_and_advance(2021, 4, 30, 1);   // 30-day month
    load_and_advance(9999, 12, 31, 1);  // year wraps to 0000
    load_and_advance(0, 0, 31, 1);      // month zero goes to January, same year
    load_and_advance(16383, 15, 31, 1); // all ones, year folds to 6383
    load_and_advance(9999, 13, 31, 1);  // month past 12 carries the year
    load_and_advance(5, 7, 0, 1);       // day zero
    load_and_advance(2022, 2, 31, 1);   // day past end of month
    load_and_advance(2020, 2, 30, 1);
    drain();

    // Random: mostly valid dates near month ends followed by runs of advances
    while (n_loads + n_advances < WORD_COUNT) begin
      if (!paused && n_loads + n_advances >= WORD_COUNT / 2) begin
        drain();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        put_word(bcdcal_pkg::KIND_LOAD, 14'($urandom_range(0, 16383)),
                 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
        steps = $urandom_range(0, 4);
      end else if (pick < 20) begin
        steps = $urandom_range(1, 6);
      end else begin
        case ($urandom_range(0, 4))
          0:       y = $urandom_range(0, 24) * 400;
          1:       y = $urandom_range(0, 99) * 100;
          2:       y = $urandom_range(0, 2499) * 4;
          3:       y = 9999;
          default: y = $urandom_range(0, 9999);
        endcase
        if ($urandom_range(0, 2) == 0) m = $urandom_range(0, 1) ? 2 : 12;
        else m = $urandom_range(1, 12);
        len = sb.month_days(m, y);
        d = $urandom_range(0, 1) ? len - $urandom_range(0, 3) : $urandom_range(1, len);
        put_word(bcdcal_pkg::KIND_LOAD, 14'(y), 4'(m), 5'(d));
        steps = $urandom_range(1, 40);
      end
      advance_days(steps);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Ran %0d loads and %0d day advances over leap, century and 9999 rollover dates",
             n_loads, n_advances);
    $display("with out-of-range loads; %0d dates compared, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.due_dates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
